// ----- design/atg_pkg.sv -----
// Shared types and constants for the arc tower grid generator.
package atg_pkg;

  localparam int unsigned IDX_W  = 27;
  localparam int unsigned BASE_W = 32;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned HP_W   = 75;

  localparam logic [CNT_W-1:0] H_MIN  = 6'd32;
  localparam logic [CNT_W-1:0] H_LAST = 6'd45;
  localparam logic [CNT_W-1:0] H_MAX  = 6'd46;

  typedef enum logic [2:0] {
    MUL_JS = 3'd0,
    MUL_RR = 3'd1,
    MUL_XX = 3'd2,
    MUL_YY = 3'd3,
    MUL_HS = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     ld_x;
    logic     ld_rsq;
    logic     ld_x2;
    logic     sq_init;
    logic     sq_step;
    logic     rnd;
    logic     ld_ysq;
    logic     h_init;
    logic     h_step;
    logic     ld_hs;
    logic     mark_done;
    logic     emit;
  } atg_cmd_t;

  typedef struct packed {
    logic fin;
    logic x_gt_r;
    logic sq_last;
    logic h_found;
    logic h_last;
    logic walk_end;
    logic out_free;
  } atg_sts_t;

endpackage

// ----- design/atg_ctrl.sv -----
// Sequencer for the arc tower grid generator.
module atg_ctrl
  import atg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  atg_sts_t sts,
  output atg_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_XMUL  = 12'b000000000010,
    S_RSQ   = 12'b000000000100,
    S_XSQ   = 12'b000000001000,
    S_SQI   = 12'b000000010000,
    S_SQRT  = 12'b000000100000,
    S_RND   = 12'b000001000000,
    S_YSQ   = 12'b000010000000,
    S_HINIT = 12'b000100000000,
    S_HGT   = 12'b001000000000,
    S_CHK   = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = MUL_JS;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_XMUL;
        end
      end
      S_XMUL: begin
        if (sts.fin) begin
          cmd.mark_done = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.mul_sel = MUL_JS;
          cmd.ld_x = 1'b1;
          state_next = S_RSQ;
        end
      end
      S_RSQ: begin
        if (sts.x_gt_r) begin
          cmd.mark_done = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.mul_sel = MUL_RR;
          cmd.ld_rsq = 1'b1;
          state_next = S_XSQ;
        end
      end
      S_XSQ: begin
        cmd.mul_sel = MUL_XX;
        cmd.ld_x2 = 1'b1;
        state_next = S_SQI;
      end
      S_SQI: begin
        cmd.sq_init = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        state_next = S_YSQ;
      end
      S_YSQ: begin
        cmd.mul_sel = MUL_YY;
        cmd.ld_ysq = 1'b1;
        state_next = S_HINIT;
      end
      S_HINIT: begin
        cmd.h_init = 1'b1;
        state_next = S_HGT;
      end
      S_HGT: begin
        cmd.h_step = 1'b1;
        if (sts.h_found || sts.h_last) state_next = S_CHK;
      end
      S_CHK: begin
        cmd.mul_sel = MUL_HS;
        cmd.ld_hs = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // walk_end is checked here once tower height times side is registered
        if (sts.out_free) begin
          if (sts.walk_end) cmd.mark_done = 1'b1;
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/atg_dp.sv -----
// Datapath: walk state, shared multiplier, serial square root, height search.
module atg_dp
  import atg_pkg::*;
#(
  parameter int unsigned SIDE_LEN    = 64,
  parameter int unsigned RADIUS_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              restart,
  input  logic              out_stall,
  input  atg_cmd_t          cmd,
  output atg_sts_t          sts,
  output logic              out_valid,
  output logic [IDX_W-1:0]  tower_index,
  output logic [BASE_W-1:0] base_height,
  output logic [CNT_W-1:0]  tile_count,
  output logic [SUM_W-1:0]  tile_offset,
  output logic [BASE_W-1:0] delta_from_previous,
  output logic              done_res
);

  localparam int unsigned SW  = $clog2(SIDE_LEN + 1);
  localparam int unsigned XW  = IDX_W + SW;
  localparam int unsigned HSW = CNT_W + SW;
  localparam int unsigned CW  = ((XW > 34) ? XW : 34) + 1;
  localparam logic [31:0] RMASK = 32'((64'd1 << RADIUS_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] IDX_LAST = '1;

  logic [31:0]       radius;
  logic [IDX_W-1:0]  tower_counter;
  logic [BASE_W-1:0] previous_base;
  logic [SUM_W-1:0]  running_tiles;
  logic              finished;
  logic              is_done;

  logic [XW-1:0]     x;
  logic [SQ_W-1:0]   rsq;
  logic [SQ_W-1:0]   x2;
  logic [SQ_W-1:0]   sq_v;
  logic [SQ_W-1:0]   sq_root;
  logic [SQ_W-1:0]   sq_bit;
  logic [4:0]        sq_cnt;
  logic [BASE_W-1:0] y;
  logic [SQ_W-1:0]   ysq;
  logic [HP_W-1:0]   hp;
  logic [HP_W-1:0]   hq;
  logic [HP_W-1:0]   ht;
  logic [CNT_W-1:0]  h;
  logic [HSW-1:0]    hs;

  logic [31:0]       r_eff;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [SQ_W-1:0]   sq_t;
  logic [BASE_W-1:0] y_rnd;
  logic [CW-1:0]     end_lhs;

  assign r_eff = radius & RMASK;

  always_comb begin
    case (cmd.mul_sel)
      MUL_JS: begin mul_a = 32'(tower_counter); mul_b = 32'(SIDE_LEN);  end
      MUL_RR: begin mul_a = r_eff;              mul_b = r_eff;          end
      MUL_XX: begin mul_a = 32'(x);             mul_b = 32'(x);         end
      MUL_YY: begin mul_a = y;                  mul_b = y;              end
      MUL_HS: begin mul_a = 32'(h);             mul_b = 32'(SIDE_LEN);  end
      default: begin mul_a = '0;                mul_b = '0;             end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  assign sq_t  = sq_root + sq_bit;
  assign y_rnd = sq_root[BASE_W-1:0] + BASE_W'(sq_v > sq_root);
  assign end_lhs = CW'(y) + CW'(hs) + CW'(2 * SIDE_LEN);

  assign sts.fin      = finished;
  assign sts.x_gt_r   = CW'(x) > CW'(r_eff);
  assign sts.sq_last  = (sq_cnt == 5'd0);
  assign sts.h_found  = (hp >= ht);
  assign sts.h_last   = (h == H_LAST);
  assign sts.walk_end = is_done || (end_lhs <= CW'(x));
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.ld_x)   x   <= XW'(prod);
    if (cmd.ld_rsq) rsq <= prod;
    if (cmd.ld_x2)  x2  <= prod;
    if (cmd.sq_init) begin
      sq_v    <= rsq - x2;
      sq_root <= '0;
      sq_bit  <= SQ_W'(1) << (SQ_W - 2);
      sq_cnt  <= 5'd31;
    end
    if (cmd.sq_step) begin
      if (sq_v >= sq_t) begin
        sq_v    <= sq_v - sq_t;
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt - 5'd1;
    end
    if (cmd.rnd) begin
      if (tower_counter != '0 && y_rnd > previous_base) y <= previous_base;
      else y <= y_rnd;
    end
    if (cmd.ld_ysq) ysq <= prod;
    if (cmd.h_init) begin
      hp <= '0;
      hq <= (HP_W'(ysq) << 6) + HP_W'(ysq);
      ht <= HP_W'(x2) << 10;
      h  <= H_MIN;
    end
    if (cmd.h_step && !sts.h_found) begin
      if (sts.h_last) begin
        h <= H_MAX;
      end else begin
        hp <= hp + hq;
        hq <= hq + (HP_W'(ysq) << 1);
        h  <= h + CNT_W'(1);
      end
    end
    if (cmd.ld_hs) hs <= HSW'(prod);
    if (cmd.emit) begin
      tower_index <= tower_counter;
      tile_offset <= running_tiles;
      if (sts.walk_end || cmd.mark_done) begin
        base_height         <= '0;
        tile_count          <= '0;
        delta_from_previous <= '0;
        done_res            <= 1'b1;
      end else begin
        base_height         <= y;
        tile_count          <= h;
        delta_from_previous <= (tower_counter == '0) ? '0 : previous_base - y;
        done_res            <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= '0;
      tower_counter <= '0;
      previous_base <= '0;
      running_tiles <= '0;
      finished      <= 1'b0;
      is_done       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) radius <= cfg_data;
      if (cmd.load_in) begin
        is_done <= 1'b0;
        if (restart) begin
          tower_counter <= '0;
          previous_base <= '0;
          running_tiles <= '0;
          finished      <= 1'b0;
        end
      end
      if (cmd.mark_done) is_done <= 1'b1;
      if (cmd.emit) begin
        if (sts.walk_end) begin
          finished <= 1'b1;
        end else begin
          previous_base <= y;
          running_tiles <= running_tiles + SUM_W'(h);
          if (tower_counter == IDX_LAST) finished <= 1'b1;
          else tower_counter <= tower_counter + IDX_W'(1);
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/arc_tower_grid_generator_unit.sv -----
// Top level of the arc tower grid generator.
//
// Each input beat (restart bit) asks for the next tower along a circle of
// radius R; restart=1 begins again at tower 0. Each input beat yields exactly
// one result beat: index, rounded non-increasing base, tile count (32..46),
// prefix tile offset and delta to the previous base, or a done beat
// (done_res=1, sticky until restart) once the walk has ended.
// Both item channels use valid/stall; the block drives in_stall and is busy
// from acceptance until its result is loaded into the output register.
// From acceptance, a repeated done beat goes from the first multiply step
// to emit, and a tower past the radius goes from the radius check; otherwise a
// 32-step serial square root of the 64-bit R^2-x^2 dominates, plus one to
// fourteen steps of the incremental height search, with one shared 32x32
// multiplier for j*S, R^2, x^2, base^2 and height*S.
// The next beat is accepted the cycle after the result is loaded.
// A result waiting under out_stall does not block acceptance; the block
// then holds in its emit step until the previous beat leaves.
// The radius register is written on the cfg channel (always ready); writes
// are meant for idle periods. Synchronous reset clears walk, radius, out_valid.
module arc_tower_grid_generator_unit
  import atg_pkg::*;
#(
  parameter int unsigned SIDE_LEN    = 64,
  parameter int unsigned RADIUS_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       radius,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  tower_index,
  output logic [BASE_W-1:0] base_height,
  output logic [CNT_W-1:0]  tile_count,
  output logic [SUM_W-1:0]  tile_offset,
  output logic [BASE_W-1:0] delta_from_previous,
  output logic              done_res
);

  atg_cmd_t cmd;
  atg_sts_t sts;

  assign cfg_ready = 1'b1;

  atg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  atg_dp #(
    .SIDE_LEN    (SIDE_LEN),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_data            (radius),
    .restart             (restart),
    .out_stall           (out_stall),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .tower_index         (tower_index),
    .base_height         (base_height),
    .tile_count          (tile_count),
    .tile_offset         (tile_offset),
    .delta_from_previous (delta_from_previous),
    .done_res            (done_res)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the arc tower grid generator unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atg_pkg::*;

  localparam int unsigned SIDE  = 64;
  localparam int unsigned LIMIT = 600000;

  // One expected or observed result beat.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [BASE_W-1:0] base;
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W-1:0]  offset;
    logic [BASE_W-1:0] delta;
    logic              done;
  } tower_beat_t;

  // Tracks the walk state and the towers still owed by the block.
  class tower_scoreboard;
    bit [31:0]        radius_reg;
    bit [IDX_W-1:0]   next_idx;
    bit [BASE_W-1:0]  prev_base;
    bit [SUM_W-1:0]   tiles;
    bit               finished;
    tower_beat_t      owed[$];
    int               mismatches;

    function bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Smallest h in 32..45 with (h^2-1024)*y^2 >= 1024*x^2, else 46.
    function bit [5:0] height_for(bit [63:0] x, bit [63:0] y);
      bit [127:0] rhs, lhs;
      if (x == 0 && y == 0) return H_MIN;
      if (y == 0) return H_MAX;
      rhs = 128'(x * x) * 128'd1024;
      for (int h = 32; h < 46; h++) begin
        lhs = 128'(y * y) * 128'(h * h - 1024);
        if (lhs >= rhs) return 6'(h);
      end
      return H_MAX;
    endfunction

    function void owe_done();
      tower_beat_t t;
      t = '0;
      t.idx = next_idx;
      t.offset = tiles;
      t.done = 1'b1;
      owed = {owed, t};
    endfunction

    // Called for each accepted input beat.
    function void note_request(bit rs);
      bit [63:0] r, x, diff, y;
      bit [5:0]  h;
      tower_beat_t t;
      if (rs) begin
        next_idx = 0; prev_base = 0; tiles = 0; finished = 0;
      end
      if (finished) begin
        owe_done();
        return;
      end
      r = 64'(radius_reg);
      x = 64'(next_idx) * SIDE;
      if (x > r) begin
        finished = 1; owe_done(); return;
      end
      diff = r * r - x * x;
      y = root_floor(diff);
      if (diff - y * y > y) y++;
      if (next_idx > 0 && y > 64'(prev_base)) y = 64'(prev_base);
      h = height_for(x, y);
      if (y + 64'(h) * SIDE + 2 * SIDE <= x) begin
        finished = 1; owe_done(); return;
      end
      t.idx = next_idx;
      t.base = y[31:0];
      t.cnt = h;
      t.offset = tiles;
      t.delta = (next_idx == 0) ? '0 : prev_base - y[31:0];
      t.done = 1'b0;
      owed = {owed, t};
      prev_base = y[31:0];
      tiles = tiles + 32'(h);
      if (next_idx == {IDX_W{1'b1}}) finished = 1;
      else next_idx = next_idx + 1;
    endfunction

    function void check_beat(tower_beat_t got);
      tower_beat_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = owed.pop_front();
      if (got.idx != want.idx || got.base != want.base || got.cnt != want.cnt ||
          got.offset != want.offset || got.delta != want.delta ||
          got.done != want.done) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [31:0]       radius = '0;
  logic              in_valid = 0;
  logic              in_stall;
  logic              restart = 0;
  logic              out_valid;
  logic              out_stall = 0;
  logic [IDX_W-1:0]  tower_index;
  logic [BASE_W-1:0] base_height;
  logic [CNT_W-1:0]  tile_count;
  logic [SUM_W-1:0]  tile_offset;
  logic [BASE_W-1:0] delta_from_previous;
  logic              done_res;

  tower_scoreboard sb = new();
  bit quiet = 0;          // no idling in the closing stretch
  int sent = 0;
  int cycles = 0;
  int stall_left = 0;

  arc_tower_grid_generator_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Monitors: sampled values at the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.radius_reg = radius;
      if (in_valid && !in_stall) sb.note_request(restart);
      if (out_valid && !out_stall)
        sb.check_beat({tower_index, base_height, tile_count, tile_offset,
                       delta_from_previous, done_res});
    end
  end

  // Receiver backpressure in random bursts.
  always @(posedge clk) begin
    if (quiet || rst) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_beat(bit rs);
    in_valid <= 1;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Block must be idle: drain owed results, then let a done beat settle.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_radius(bit [31:0] v);
    drain();
    cfg_valid <= 1;
    radius <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // Write a radius and walk n towers; fresh starts with a restart beat.
  task automatic walk(bit [31:0] v, int n, bit fresh);
    set_radius(v);
    for (int i = 0; i < n; i++)
      send_beat((i == 0 && fresh) || $urandom_range(0, 40) == 0);
  endtask

  initial begin
    bit [31:0] v;
    int n;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: zero radius (done after tower 0, sticky), full radius, tiny radii
    // that run into the walk-end test, and a radius change mid-walk.
    walk(32'd0, 3, 1);
    send_beat(1);
    walk(32'hFFFF_FFFF, 4, 1);
    walk(32'd64, 4, 1);
    walk(32'd200, 6, 1);
    walk(32'd700, 4, 0);

    while (sent < 600) begin
      if (sent > 510) quiet = 1;
      case ($urandom_range(0, 9))
        0: v = 32'hFFFF_FFFF;
        1: v = $urandom();
        default: v = $urandom_range(0, 6000);
      endcase
      n = $urandom_range(5, 100);
      if (n > 600 - sent) n = 600 - sent;
      walk(v, n, $urandom_range(0, 7) != 0);
    end

    drain();
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
